@@ src/bdel_pkg.sv @@
// bdel_pkg: shared types, codes and defaults for the bounded double-ended list unit
// used by bdel_ctrl, bdel_dp and bounded_double_ended_list_unit; depends on nothing
package bdel_pkg;

   localparam int CAPACITY_DEFAULT   = 256;
   localparam int ENTRY_BITS_DEFAULT = 32;

   localparam int REQ_TYPE_BITS = 3;
   localparam int VALUE_BITS    = 32;
   localparam int POSITION_BITS = 8;
   localparam int COUNT_BITS    = 9;
   localparam int STATUS_BITS   = 2;

   localparam logic [REQ_TYPE_BITS-1:0] REQ_PUSH_HEAD = 3'd0;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_PUSH_TAIL = 3'd1;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_POP_HEAD  = 3'd2;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_POP_TAIL  = 3'd3;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_READ_HEAD = 3'd4;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_READ_TAIL = 3'd5;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_READ_POS  = 3'd6;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      END_HEAD,
      END_TAIL,
      END_POS
   } end_type;

   typedef struct packed {
      logic    exec;
      logic    push;
      logic    pop;
      logic    rd;
      end_type sel;
   } cmd_type;

endpackage

@@ src/bdel_ctrl.sv @@
// bdel_ctrl: request decoder and handshake state machine
// depends on bdel_pkg; drives the command struct into bdel_dp
module bdel_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [bdel_pkg::REQ_TYPE_BITS-1:0]  req_type,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdel_pkg::cmd_type                   cmd
);

   bdel_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdel_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdel_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bdel_pkg::ST_RESP;
            end
         end
         bdel_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = bdel_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bdel_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and request decode
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         bdel_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.exec  = req_valid;
         end
         bdel_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase

      cmd.push = 1'b0;
      cmd.pop  = 1'b0;
      cmd.rd   = 1'b0;
      cmd.sel  = bdel_pkg::END_HEAD;
      case (req_type) inside
         bdel_pkg::REQ_PUSH_HEAD, bdel_pkg::REQ_PUSH_TAIL: cmd.push = 1'b1;
         bdel_pkg::REQ_POP_HEAD, bdel_pkg::REQ_POP_TAIL:   cmd.pop  = 1'b1;
         bdel_pkg::REQ_READ_HEAD, bdel_pkg::REQ_READ_TAIL,
         bdel_pkg::REQ_READ_POS:                           cmd.rd   = 1'b1;
         default: begin
            cmd.push = 1'b0;
         end
      endcase
      case (req_type) inside
         bdel_pkg::REQ_PUSH_TAIL, bdel_pkg::REQ_POP_TAIL,
         bdel_pkg::REQ_READ_TAIL: cmd.sel = bdel_pkg::END_TAIL;
         bdel_pkg::REQ_READ_POS:  cmd.sel = bdel_pkg::END_POS;
         default:                 cmd.sel = bdel_pkg::END_HEAD;
      endcase
   end

   a_resp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no response after accepted word");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (req_stall && !cmd.exec))
      else $error("request taken while response pending");

   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

endmodule

@@ src/bdel_dp.sv @@
// bdel_dp: circular entry store, head pointer, count and result registers
// depends on bdel_pkg; commanded by bdel_ctrl
module bdel_dp #(
   parameter int CAPACITY   = bdel_pkg::CAPACITY_DEFAULT,
   parameter int ENTRY_BITS = bdel_pkg::ENTRY_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bdel_pkg::cmd_type                    cmd,
   input  logic [bdel_pkg::VALUE_BITS-1:0]      entry_value,
   input  logic [bdel_pkg::POSITION_BITS-1:0]   position,
   output logic [bdel_pkg::VALUE_BITS-1:0]      read_value,
   output logic [bdel_pkg::COUNT_BITS-1:0]      item_count,
   output logic [bdel_pkg::STATUS_BITS-1:0]     status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int OW = (CW > bdel_pkg::POSITION_BITS) ? CW : bdel_pkg::POSITION_BITS;
   localparam int SW = OW + 1;

   logic [ENTRY_BITS-1:0] entry_store_ff [CAPACITY];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [bdel_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic                  hit_ff, hit_in;

   logic          full, empty, wr_en;
   logic [OW-1:0] offset;
   logic [SW-1:0] slot_sum, slot_wrap;
   logic [AW-1:0] slot, prev_head, wr_addr;

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      case (cmd.sel)
         bdel_pkg::END_HEAD: offset = cmd.pop ? OW'(1) : '0;
         bdel_pkg::END_TAIL: offset = cmd.push ? OW'(count_ff) : OW'(count_ff - CW'(1));
         bdel_pkg::END_POS:  offset = OW'(position);
         default:            offset = '0;
      endcase
   end

   // head plus offset, wrapped once around the store
   assign slot_sum  = SW'(head_ff) + SW'(offset);
   assign slot_wrap = (slot_sum >= SW'(CAPACITY)) ? (slot_sum - SW'(CAPACITY)) : slot_sum;
   assign slot      = AW'(slot_wrap);
   assign prev_head = (head_ff == '0) ? AW'(CAPACITY - 1) : (head_ff - AW'(1));

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = bdel_pkg::STATUS_OK;
      hit_in    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = slot;
      if (cmd.push) begin
         if (full) begin
            status_in = bdel_pkg::STATUS_FULL;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            if (cmd.sel == bdel_pkg::END_HEAD) begin
               wr_addr = prev_head;
               head_in = prev_head;
            end
         end
      end else if (cmd.pop) begin
         if (empty) begin
            status_in = bdel_pkg::STATUS_EMPTY;
         end else begin
            count_in = count_ff - CW'(1);
            if (cmd.sel == bdel_pkg::END_HEAD) begin
               head_in = slot;
            end
         end
      end else if (cmd.rd) begin
         if (empty) begin
            status_in = bdel_pkg::STATUS_EMPTY;
         end else if (cmd.sel == bdel_pkg::END_POS && OW'(position) >= OW'(count_ff)) begin
            status_in = bdel_pkg::STATUS_RANGE;
         end else begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff  <= status_in;
         hit_ff     <= hit_in;
         rd_data_ff <= entry_store_ff[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         entry_store_ff[wr_addr] <= ENTRY_BITS'(entry_value);
      end
   end

   assign read_value = hit_ff ? bdel_pkg::VALUE_BITS'(rd_data_ff) : '0;
   assign item_count = bdel_pkg::COUNT_BITS'(count_ff);
   assign status     = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      32'(head_ff) < CAPACITY)
      else $error("head pointer outside store");

   a_full_push_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && cmd.push && full) |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("dropped push changed list state");

endmodule

@@ src/bounded_double_ended_list_unit.sv @@
// Bounded double-ended list: CAPACITY entries of ENTRY_BITS held in a circular store
// with a head pointer. A request is accepted when req_valid is high and req_stall low,
// its result shows on the rsp_ ports in the following cycle, and req_stall stays high
// until that word is taken, so at most one request is in flight. The controller takes
// no new request while a result is held; the store's registered read port delivers
// the entry in the cycle after the request. No clearing pass runs after reset;
// entries are only read after they were written.
module bounded_double_ended_list_unit #(
   parameter int CAPACITY   = bdel_pkg::CAPACITY_DEFAULT,
   parameter int ENTRY_BITS = bdel_pkg::ENTRY_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bdel_pkg::REQ_TYPE_BITS-1:0]  req_type,
   input  logic [bdel_pkg::VALUE_BITS-1:0]     req_entry_value,
   input  logic [bdel_pkg::POSITION_BITS-1:0]  req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bdel_pkg::VALUE_BITS-1:0]     rsp_read_value,
   output logic [bdel_pkg::COUNT_BITS-1:0]     rsp_item_count,
   output logic [bdel_pkg::STATUS_BITS-1:0]    rsp_status
);

   bdel_pkg::cmd_type cmd;

   bdel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bdel_dp #(
      .CAPACITY   (CAPACITY),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .entry_value (req_entry_value),
      .position    (req_position),
      .read_value  (rsp_read_value),
      .item_count  (rsp_item_count),
      .status      (rsp_status)
   );

endmodule

@@ sim/tb_bounded_double_ended_list_unit.sv @@
// Self-checking bench for bounded_double_ended_list_unit: a shadow deque predicts every
// reply word; directed edge cases then goal-driven random fill and drain under varied idling.
// Depends on bdel_pkg and the unit itself.
`timescale 1ns / 100ps

module tb_bounded_double_ended_list_unit;

   localparam int CAP = bdel_pkg::CAPACITY_DEFAULT;

   typedef struct packed {
      logic [bdel_pkg::VALUE_BITS-1:0]  read_value;
      logic [bdel_pkg::COUNT_BITS-1:0]  item_count;
      logic [bdel_pkg::STATUS_BITS-1:0] status;
   } reply_type;

   class deque_scoreboard;
      logic [bdel_pkg::VALUE_BITS-1:0] store [CAP];
      int head;
      int count;
      int errors;
      reply_type replies [$];

      function new();
         head = 0;
         count = 0;
         errors = 0;
      endfunction

      function void note_request(logic [bdel_pkg::REQ_TYPE_BITS-1:0] kind,
                                 logic [bdel_pkg::VALUE_BITS-1:0] value,
                                 logic [bdel_pkg::POSITION_BITS-1:0] pos);
         reply_type r;
         r = '0;
         r.status = bdel_pkg::STATUS_OK;
         case (kind)
            bdel_pkg::REQ_PUSH_HEAD, bdel_pkg::REQ_PUSH_TAIL: begin
               if (count >= CAP) begin
                  r.status = bdel_pkg::STATUS_FULL;
               end else begin
                  if (kind == bdel_pkg::REQ_PUSH_HEAD) begin
                     head = (head + CAP - 1) % CAP;
                     store[head] = value;
                  end else begin
                     store[(head + count) % CAP] = value;
                  end
                  count++;
               end
            end
            bdel_pkg::REQ_POP_HEAD, bdel_pkg::REQ_POP_TAIL: begin
               if (count == 0) begin
                  r.status = bdel_pkg::STATUS_EMPTY;
               end else begin
                  if (kind == bdel_pkg::REQ_POP_HEAD) head = (head + 1) % CAP;
                  count--;
               end
            end
            bdel_pkg::REQ_READ_HEAD, bdel_pkg::REQ_READ_TAIL, bdel_pkg::REQ_READ_POS: begin
               if (count == 0) r.status = bdel_pkg::STATUS_EMPTY;
               else if (kind == bdel_pkg::REQ_READ_HEAD) r.read_value = store[head];
               else if (kind == bdel_pkg::REQ_READ_TAIL)
                  r.read_value = store[(head + count - 1) % CAP];
               else if (int'(pos) >= count) r.status = bdel_pkg::STATUS_RANGE;
               else r.read_value = store[(head + int'(pos)) % CAP];
            end
            default: begin
            end
         endcase
         r.item_count = bdel_pkg::COUNT_BITS'(count);
         replies.push_back(r);
      endfunction

      function void check_result(logic [bdel_pkg::VALUE_BITS-1:0] value,
                                 logic [bdel_pkg::COUNT_BITS-1:0] cnt,
                                 logic [bdel_pkg::STATUS_BITS-1:0] st);
         reply_type want;
         if (replies.size() == 0) begin
            $display("%0t unexpected word: value %h count %0d status %0d",
                     $time, value, cnt, st);
            errors++;
            return;
         end
         want = replies.pop_front();
         if (value !== want.read_value) begin
            $display("%0t read_value: expected %h, actual %h", $time, want.read_value, value);
            errors++;
         end
         if (cnt !== want.item_count) begin
            $display("%0t item_count: expected %0d, actual %0d", $time, want.item_count, cnt);
            errors++;
         end
         if (st !== want.status) begin
            $display("%0t status: expected %0d, actual %0d", $time, want.status, st);
            errors++;
         end
      endfunction

      function int pending();
         return replies.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [bdel_pkg::REQ_TYPE_BITS-1:0]  req_type = bdel_pkg::REQ_PUSH_HEAD;
   logic [bdel_pkg::VALUE_BITS-1:0]     req_entry_value = '0;
   logic [bdel_pkg::POSITION_BITS-1:0]  req_position = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [bdel_pkg::VALUE_BITS-1:0]     rsp_read_value;
   logic [bdel_pkg::COUNT_BITS-1:0]     rsp_item_count;
   logic [bdel_pkg::STATUS_BITS-1:0]    rsp_status;

   int idle_pct = 0;
   int stall_pct = 0;
   deque_scoreboard board;

   bounded_double_ended_list_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_entry_value (req_entry_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_item_count  (rsp_item_count),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // reply side: take words and pick next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_read_value, rsp_item_count, rsp_status);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send(input logic [bdel_pkg::REQ_TYPE_BITS-1:0] kind,
                       input logic [bdel_pkg::VALUE_BITS-1:0] value,
                       input logic [bdel_pkg::POSITION_BITS-1:0] pos);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_entry_value <= value;
      req_position    <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(kind, value, pos);
   endtask

   // walk the fill level toward a goal, with reads and some noise
   task automatic random_request(inout int goal);
      int roll;
      int level;
      logic [bdel_pkg::REQ_TYPE_BITS-1:0] kind;
      logic [bdel_pkg::VALUE_BITS-1:0] value;
      logic [bdel_pkg::POSITION_BITS-1:0] pos;
      level = board.count;
      if (level == goal) begin
         roll = $urandom_range(9);
         if (roll < 3) goal = CAP;
         else if (roll < 6) goal = 0;
         else goal = $urandom_range(CAP);
      end
      value = $urandom;
      if ($urandom_range(15) == 0) value = $urandom_range(1) ? '1 : '0;
      pos = bdel_pkg::POSITION_BITS'($urandom);
      if (level > 0 && $urandom_range(3) != 0)
         pos = bdel_pkg::POSITION_BITS'($urandom_range(level - 1));
      else if ($urandom_range(1) == 0)
         pos = bdel_pkg::POSITION_BITS'(level);
      roll = $urandom_range(99);
      if (roll < 5)
         kind = bdel_pkg::REQ_TYPE_BITS'($urandom_range(bdel_pkg::REQ_READ_POS,
                                                        bdel_pkg::REQ_PUSH_HEAD));
      else if (roll < 25)
         kind = bdel_pkg::REQ_TYPE_BITS'($urandom_range(bdel_pkg::REQ_READ_POS,
                                                        bdel_pkg::REQ_READ_HEAD));
      else if ((roll < 85) == (level < goal))
         kind = $urandom_range(1) ? bdel_pkg::REQ_PUSH_HEAD : bdel_pkg::REQ_PUSH_TAIL;
      else
         kind = $urandom_range(1) ? bdel_pkg::REQ_POP_HEAD : bdel_pkg::REQ_POP_TAIL;
      send(kind, value, pos);
   endtask

   initial begin
      int goal;
      int idle_set [4];
      int stall_set [4];
      board = new();
      goal = CAP;
      idle_set  = '{0, 76, 0, 22};
      stall_set = '{0, 0, 76, 22};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty list
      send(bdel_pkg::REQ_READ_HEAD, 32'h1234_5678, 8'd0);
      send(bdel_pkg::REQ_READ_TAIL, 32'h0, 8'd0);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd0);
      send(bdel_pkg::REQ_POP_HEAD, 32'h0, 8'd0);
      send(bdel_pkg::REQ_POP_TAIL, 32'h0, 8'd0);
      // both ends, extreme values
      send(bdel_pkg::REQ_PUSH_TAIL, 32'h0000_0000, 8'd0);
      send(bdel_pkg::REQ_PUSH_HEAD, 32'hFFFF_FFFF, 8'd0);
      send(bdel_pkg::REQ_PUSH_TAIL, 32'hA5A5_A5A5, 8'hFF);
      send(bdel_pkg::REQ_PUSH_HEAD, 32'h5A5A_5A5A, 8'h00);
      send(bdel_pkg::REQ_READ_HEAD, 32'h0, 8'd0);
      send(bdel_pkg::REQ_READ_TAIL, 32'h0, 8'd0);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd0);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd3);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd4);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd255);
      send(bdel_pkg::REQ_POP_HEAD, 32'h0, 8'd0);
      send(bdel_pkg::REQ_POP_TAIL, 32'h0, 8'd0);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd1);
      send(bdel_pkg::REQ_POP_TAIL, 32'h0, 8'd0);
      send(bdel_pkg::REQ_POP_HEAD, 32'h0, 8'd0);
      send(bdel_pkg::REQ_POP_HEAD, 32'h0, 8'd0);
      send(bdel_pkg::REQ_READ_POS, 32'h0, 8'd128);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_set[phase];
         stall_pct = stall_set[phase];
         repeat (500) random_request(goal);
         // hold off until every reply is back
         req_valid <= 1'b0;
         while (board.pending() != 0) @(posedge clock);
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
